@@ sv/dwcfi_pkg.sv @@
`default_nettype none

package dwcfi_pkg;

  // Store depths of the two windows, in bytes.
  localparam int WINDOW0_BYTES = 1048576;
  localparam int WINDOW1_BYTES = 1048576;

  localparam int W0_AW = $clog2(WINDOW0_BYTES);
  localparam int W1_AW = $clog2(WINDOW1_BYTES);

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int HALF_W = 16;
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 21;

  // An effective size may equal the store depth, so it needs one bit more than an offset.
  localparam int W0_EFF_W = (SIZE_W > W0_AW + 1) ? SIZE_W : W0_AW + 1;
  localparam int W1_EFF_W = (SIZE_W > W1_AW + 1) ? SIZE_W : W1_AW + 1;

  // The erase sweep after reset runs over the deeper of the two stores.
  localparam int CLR_BYTES = (WINDOW0_BYTES > WINDOW1_BYTES) ? WINDOW0_BYTES : WINDOW1_BYTES;
  localparam int CLR_W     = $clog2(CLR_BYTES);

  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int REQ_W       = 3;
  localparam int OUT_TUSER_W = 2;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request kinds as they arrive on the bus.
  localparam logic [REQ_W-1:0] REQ_READ8   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ16  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ32  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE8  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WRITE16 = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WRITE32 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_LOAD0   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_LOAD1   = 3'd7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_W0_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W0_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W1_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W1_SIZE = 3'd3;

  localparam logic [SIZE_W-1:0] RESET_SIZE = 21'd1048576;

  localparam logic [BYTE_W-1:0] ERASED_BYTE        = 8'hFF;
  localparam logic [ADDR_W-1:0] QUERY_ENTER_OFFSET = 32'h0000_00AA;
  localparam logic [HALF_W-1:0] QUERY_ENTER_VALUE  = 16'h0098;
  localparam logic [HALF_W-1:0] QUERY_EXIT_VALUE   = 16'h00F0;
  localparam logic [ADDR_W-1:0] QUERY_TABLE_FIRST  = 32'h0000_0020;
  localparam logic [ADDR_W-1:0] QUERY_TABLE_LAST   = 32'h0000_0029;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE16,
    OP_REJECT,
    OP_LOAD0,
    OP_LOAD1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        last_idx;
    logic [ADDR_W-1:0] address;
    logic [HALF_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } bst_t;

  typedef enum logic [1:0] {
    SRC_W0,
    SRC_W1,
    SRC_TAB,
    SRC_ERASED
  } src_t;

  // Identification table seen in window 1 at offsets 0x20 to 0x29 in query mode.
  function automatic logic [BYTE_W-1:0] query_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd1:    b = 8'h51;
      4'd3:    b = 8'h52;
      4'd5:    b = 8'h59;
      4'd7:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/dual_window_flash_cfi_query.sv @@
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_tvalid/in_tready  | tdata: address, write_data; tuser: req_type
// out     | output    | out_tvalid/out_tready| tdata: read_data; tuser: rejected, query_mode
// cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A write or load is handled in the back end's idle state; a read fetches its bytes in
// turn, as each window store has a single read port and delivers one byte per cycle.
// After reset both stores are swept to 0xFF; no item is accepted during the sweep,
// though configuration writes are.
// A two-entry queue lets input be accepted while the back end or the output stalls.

module dual_window_flash_cfi_query import dwcfi_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // address [31:0], write_data [63:32]
  input  wire logic [REQ_W-1:0]       in_tuser,   // req_type [2:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [DATA_W-1:0]           out_tdata,  // read_data [31:0]
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // rejected [0], query_mode [1]
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [DATA_W-1:0]      cfg_data
);

  logic q_ready;
  logic q_push;
  cmd_t q_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;
  logic clearing;

  assign cfg_ready = 1'b1;

  dwcfi_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  dwcfi_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .q_ready  (q_ready),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  dwcfi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input accepted during the erase sweep");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  a_rejected_has_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("rejected transaction carries read data");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("command queue written while full");

endmodule

`default_nettype wire

@@ sv/dwcfi_front.sv @@
`default_nettype none

module dwcfi_front import dwcfi_pkg::*; (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,  // address [31:0], write_data [63:32]
  input  wire logic [REQ_W-1:0]      in_tuser,  // req_type [2:0]
  input  wire logic                  q_ready,
  input  wire logic                  clearing,
  output logic                       q_push,
  output cmd_t                       q_cmd
);

  assign in_tready = q_ready && !clearing;
  assign q_push    = in_tvalid && in_tready;

  // Only the low half of the write data matters: write16 takes 16 bits, loads take 8.
  always_comb begin
    q_cmd.address  = in_tdata[ADDR_W-1:0];
    q_cmd.data     = in_tdata[ADDR_W +: HALF_W];
    q_cmd.last_idx = 2'd0;
    q_cmd.op       = OP_REJECT;
    unique case (in_tuser)
      REQ_READ8: begin
        q_cmd.op = OP_READ;
      end
      REQ_READ16: begin
        q_cmd.op       = OP_READ;
        q_cmd.last_idx = 2'd1;
      end
      REQ_READ32: begin
        q_cmd.op       = OP_READ;
        q_cmd.last_idx = 2'd3;
      end
      REQ_WRITE16: q_cmd.op = OP_WRITE16;
      REQ_LOAD0:   q_cmd.op = OP_LOAD0;
      REQ_LOAD1:   q_cmd.op = OP_LOAD1;
      REQ_WRITE8,
      REQ_WRITE32: q_cmd.op = OP_REJECT;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/dwcfi_fifo.sv @@
`default_nettype none

module dwcfi_fifo import dwcfi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      q_ready,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_head
);

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ sv/dwcfi_back.sv @@
`default_nettype none

module dwcfi_back import dwcfi_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [DATA_W-1:0]      cfg_data,
  input  wire logic                   q_valid,
  input  wire cmd_t                   q_head,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [DATA_W-1:0]           out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] off;
  } dec_t;

  // Hit test as offset below size, so that base plus size never has to be formed.
  function automatic dec_t win_decode(input logic [ADDR_W-1:0] a,
                                      input logic [ADDR_W-1:0] base,
                                      input logic [ADDR_W-1:0] eff);
    logic [ADDR_W:0] diff;
    dec_t            d;
    diff  = {1'b0, a} - {1'b0, base};
    d.off = diff[ADDR_W-1:0];
    d.hit = !diff[ADDR_W] && (diff[ADDR_W-1:0] < eff);
    return d;
  endfunction

  logic [ADDR_W-1:0] w0_base_r, w1_base_r;
  logic [SIZE_W-1:0] w0_size_r, w1_size_r;
  logic [W0_EFF_W-1:0] eff0;
  logic [W1_EFF_W-1:0] eff1;

  logic [BYTE_W-1:0] mem0 [WINDOW0_BYTES];
  logic [BYTE_W-1:0] mem1 [WINDOW1_BYTES];
  logic              m0_we, m1_we;
  logic [W0_AW-1:0]  m0_wa, m0_ra;
  logic [W1_AW-1:0]  m1_wa, m1_ra;
  logic [BYTE_W-1:0] m0_wd, m1_wd;
  logic [BYTE_W-1:0] m0_q_r, m1_q_r;

  bst_t              state_r, state_nxt;
  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              query_r, query_nxt;
  logic [ADDR_W-1:0] byte_addr_r, byte_addr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        last_idx_r, last_idx_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              vld_r, vld_nxt;
  src_t              src_r, src_nxt;
  logic [BYTE_W-1:0] tab_r, tab_nxt;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_rej_r, out_rej_nxt;
  logic              out_qm_r, out_qm_nxt;

  logic [ADDR_W-1:0] dec_addr;
  dec_t              dec0, dec1;
  logic              ok_fin;
  logic [BYTE_W-1:0] rbyte;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_base_r <= '0;
      w0_size_r <= RESET_SIZE;
      w1_base_r <= '0;
      w1_size_r <= RESET_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_W0_BASE: w0_base_r <= cfg_data;
        CFG_W0_SIZE: w0_size_r <= cfg_data[SIZE_W-1:0];
        CFG_W1_BASE: w1_base_r <= cfg_data;
        CFG_W1_SIZE: w1_size_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff0 = (W0_EFF_W'(w0_size_r) < W0_EFF_W'(WINDOW0_BYTES)) ?
                W0_EFF_W'(w0_size_r) : W0_EFF_W'(WINDOW0_BYTES);
  assign eff1 = (W1_EFF_W'(w1_size_r) < W1_EFF_W'(WINDOW1_BYTES)) ?
                W1_EFF_W'(w1_size_r) : W1_EFF_W'(WINDOW1_BYTES);

  // One decoder per window, shared between the byte reads and the command write.
  assign dec_addr = (state_r == ST_READ) ? byte_addr_r : q_head.address;
  assign dec0     = win_decode(dec_addr, w0_base_r, ADDR_W'(eff0));
  assign dec1     = win_decode(dec_addr, w1_base_r, ADDR_W'(eff1));
  assign m0_ra    = dec0.off[W0_AW-1:0];
  assign m1_ra    = dec1.off[W1_AW-1:0];

  assign ok_fin   = !out_tvalid_r || out_tready;
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    src_nxt = SRC_ERASED;
    tab_nxt = query_byte(dec1.off[3:0]);
    if (dec0.hit) begin
      src_nxt = SRC_W0;
    end else if (dec1.hit) begin
      if (query_r && dec1.off >= QUERY_TABLE_FIRST && dec1.off <= QUERY_TABLE_LAST) begin
        src_nxt = SRC_TAB;
      end else begin
        src_nxt = SRC_W1;
      end
    end
  end

  always_comb begin
    unique case (src_r)
      SRC_W0:     rbyte = m0_q_r;
      SRC_W1:     rbyte = m1_q_r;
      SRC_TAB:    rbyte = tab_r;
      SRC_ERASED: rbyte = ERASED_BYTE;
    endcase
  end

  always_comb begin
    logic rej;
    rej            = 1'b0;
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    query_nxt      = query_r;
    byte_addr_nxt  = byte_addr_r;
    cnt_nxt        = cnt_r;
    last_idx_nxt   = last_idx_r;
    acc_nxt        = vld_r ? {acc_r[DATA_W-BYTE_W-1:0], rbyte} : acc_r;
    vld_nxt        = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_rej_nxt    = out_rej_r;
    out_qm_nxt     = out_qm_r;
    q_pop          = 1'b0;
    m0_we          = 1'b0;
    m1_we          = 1'b0;
    m0_wa          = q_head.address[W0_AW-1:0];
    m1_wa          = q_head.address[W1_AW-1:0];
    m0_wd          = q_head.data[BYTE_W-1:0];
    m1_wd          = q_head.data[BYTE_W-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        m0_we       = (32'(clr_cnt_r) < 32'(WINDOW0_BYTES));
        m1_we       = (32'(clr_cnt_r) < 32'(WINDOW1_BYTES));
        m0_wa       = clr_cnt_r[W0_AW-1:0];
        m1_wa       = clr_cnt_r[W1_AW-1:0];
        m0_wd       = ERASED_BYTE;
        m1_wd       = ERASED_BYTE;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.op == OP_READ) begin
            q_pop         = 1'b1;
            byte_addr_nxt = q_head.address;
            cnt_nxt       = 2'd0;
            last_idx_nxt  = q_head.last_idx;
            acc_nxt       = '0;
            state_nxt     = ST_READ;
          end else if (ok_fin) begin
            q_pop = 1'b1;
            unique case (q_head.op)
              OP_WRITE16: begin
                // Enter takes precedence; the exit value works at any window-1 offset.
                if (dec1.hit && dec1.off == QUERY_ENTER_OFFSET &&
                    q_head.data == QUERY_ENTER_VALUE) begin
                  query_nxt = 1'b1;
                end else if (dec1.hit && q_head.data == QUERY_EXIT_VALUE) begin
                  query_nxt = 1'b0;
                end else begin
                  rej = 1'b1;
                end
              end
              OP_LOAD0: begin
                if (ADDR_W'(eff0) > q_head.address) begin
                  m0_we = 1'b1;
                end else begin
                  rej = 1'b1;
                end
              end
              OP_LOAD1: begin
                if (ADDR_W'(eff1) > q_head.address) begin
                  m1_we = 1'b1;
                end else begin
                  rej = 1'b1;
                end
              end
              default: rej = 1'b1;
            endcase
            out_tvalid_nxt = 1'b1;
            out_data_nxt   = '0;
            out_rej_nxt    = rej;
            out_qm_nxt     = query_nxt;
          end
        end
      end

      ST_READ: begin
        // One byte address per cycle; its data comes back from the store in the next cycle.
        vld_nxt       = 1'b1;
        byte_addr_nxt = byte_addr_r + 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == last_idx_r) begin
          state_nxt = ST_WAIT;
        end
      end

      ST_WAIT: begin
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (ok_fin) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = acc_r;
          out_rej_nxt    = 1'b0;
          out_qm_nxt     = query_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      query_r      <= 1'b0;
      vld_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      query_r      <= query_nxt;
      vld_r        <= vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_addr_r <= byte_addr_nxt;
    cnt_r       <= cnt_nxt;
    last_idx_r  <= last_idx_nxt;
    acc_r       <= acc_nxt;
    src_r       <= src_nxt;
    tab_r       <= tab_nxt;
    out_data_r  <= out_data_nxt;
    out_rej_r   <= out_rej_nxt;
    out_qm_r    <= out_qm_nxt;
  end

  always_ff @(posedge clk) begin
    if (m0_we) begin
      mem0[m0_wa] <= m0_wd;
    end
    m0_q_r <= mem0[m0_ra];
  end

  always_ff @(posedge clk) begin
    if (m1_we) begin
      mem1[m1_wa] <= m1_wd;
    end
    m1_q_r <= mem1[m1_ra];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_qm_r, out_rej_r};

endmodule

`default_nettype wire
